// ===== rtl/ffra_pkg.sv =====
// Shared types, constants and codes of the first-fit region allocator.
`default_nettype none

package ffra_pkg;

   // Region memory depth and derived widths
   localparam int MAX_REGIONS = 1024;
   localparam int IDX_W       = $clog2(MAX_REGIONS);
   localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

   // Field widths
   localparam int TYPE_W  = 8;
   localparam int ADDR_W  = 52;
   localparam int PAGES_W = 40;
   localparam int BYTES_W = 40;
   localparam int PAGE_SHIFT = 12;
   localparam int NEED_W  = BYTES_W - PAGE_SHIFT + 1;

   // Register reset values
   localparam logic [TYPE_W-1:0] USABLE_TYPE_RESET = 8'd7;
   localparam logic [ADDR_W-1:0] MIN_BASE_RESET    = 52'h30_0000;

   // Configuration register indexes
   localparam logic CSR_USABLE_TYPE = 1'b0;
   localparam logic CSR_MIN_BASE    = 1'b1;

   // Commands
   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_REJECTED = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_NO_FIT   = 2'd3
   } status_type;

   typedef struct packed {
      logic                command;
      logic [TYPE_W-1:0]   descriptor_type;
      logic [ADDR_W-1:0]   region_start;
      logic [PAGES_W-1:0]  region_page_count;
      logic [BYTES_W-1:0]  request_bytes;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [ADDR_W-1:0]   granted_address;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   base;
      logic [PAGES_W-1:0]  pages;
   } region_entry_type;

endpackage

`default_nettype wire

// ===== rtl/first_fit_region_allocator.sv =====
// Top level of the first-fit region allocator: region memory, scan sequencer, result register.
// Steps: an add is checked and stored on acceptance, then its result goes to the result register;
//   an allocate walks the stored regions in order (one region memory read per cycle) to the first fit.
// One item at a time: a new item is taken only after the last result has entered the result register.
// Reset: synchronous, active high; clears the region count, sequencer and result valid,
//   and loads the register reset values. Region memory contents are not cleared.
`default_nettype none

module first_fit_region_allocator (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire ffra_pkg::req_type req,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      ffra_pkg::rsp_type rsp,
   input  wire logic              csr_valid,
   output      logic              csr_ready,
   input  wire logic              csr_index,
   input  wire logic [51:0]       csr_wdata
);
   import ffra_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   // Registers
   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [NEED_W-1:0]      need_ff, need_in;
   status_type             status_ff, status_in;
   logic [ADDR_W-1:0]      grant_ff, grant_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;
   logic [TYPE_W-1:0]      usable_type_ff;
   logic [ADDR_W-1:0]      min_base_ff;

   // Region memory
   region_entry_type       region_mem [MAX_REGIONS];
   region_entry_type       rd_data_ff;
   logic [IDX_W-1:0]       rd_addr;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   region_entry_type       mem_wdata;

   logic [NEED_W-1:0]      req_need;
   logic                   fits;
   logic [ADDR_W-1:0]      advance;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Round the byte count up to whole pages
   assign req_need = NEED_W'(req.request_bytes[BYTES_W-1:PAGE_SHIFT])
                   + NEED_W'(|req.request_bytes[PAGE_SHIFT-1:0]);

   assign fits    = rd_data_ff.pages >= PAGES_W'(need_ff);
   assign advance = ADDR_W'({need_ff, {PAGE_SHIFT{1'b0}}});

   // Sequencer: add, scan, hand over result
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      need_in      = need_ff;
      status_in    = status_ff;
      grant_in     = grant_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in       = rsp_ff;
      rd_addr      = '0;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = rd_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               grant_in = '0;
               state_in = ST_FINISH;
               if (req.command == CMD_ADD) begin
                  if (count_ff >= CNT_W'(MAX_REGIONS - 1)) begin
                     status_in = STATUS_FULL;
                  end else if (req.descriptor_type != usable_type_ff
                               || req.region_start < min_base_ff) begin
                     status_in = STATUS_REJECTED;
                  end else begin
                     mem_we          = 1'b1;
                     mem_waddr       = count_ff[IDX_W-1:0];
                     mem_wdata.base  = req.region_start;
                     mem_wdata.pages = req.region_page_count;
                     count_in        = count_ff + CNT_W'(1);
                     status_in       = STATUS_DONE;
                  end
               end else begin
                  need_in = req_need;
                  idx_in  = '0;
                  if (count_ff == '0) begin
                     status_in = STATUS_NO_FIT;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (fits) begin
               // Grant the region and write back its shrunk entry
               mem_we          = 1'b1;
               mem_waddr       = idx_ff;
               mem_wdata.base  = rd_data_ff.base + advance;
               mem_wdata.pages = rd_data_ff.pages - PAGES_W'(need_ff);
               grant_in        = rd_data_ff.base;
               status_in       = STATUS_DONE;
               state_in        = ST_FINISH;
            end else if (CNT_W'(idx_ff) + CNT_W'(1) == count_ff) begin
               status_in = STATUS_NO_FIT;
               state_in  = ST_FINISH;
            end else begin
               idx_in  = idx_ff + IDX_W'(1);
               rd_addr = idx_ff + IDX_W'(1);
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_in.status          = status_ff;
               rsp_in.granted_address = grant_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         usable_type_ff <= USABLE_TYPE_RESET;
         min_base_ff    <= MIN_BASE_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_USABLE_TYPE: usable_type_ff <= csr_wdata[TYPE_W-1:0];
               CSR_MIN_BASE:    min_base_ff    <= csr_wdata;
               default:         min_base_ff    <= min_base_ff;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      need_ff   <= need_in;
      status_ff <= status_in;
      grant_ff  <= grant_in;
      rsp_ff    <= rsp_in;
   end

   // Region memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         region_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= region_mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/ffra_checker.sv =====
// Port-level checks for the first-fit region allocator, bound to the top level.
`default_nettype none

module ffra_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire ffra_pkg::rsp_type rsp,
   input wire logic              csr_valid,
   input wire logic              csr_ready
);
   import ffra_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("stalled result changed or dropped");

   // Only a granted allocation carries an address
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status != STATUS_DONE |-> rsp.granted_address == '0)
      else $error("address on a result that grants nothing");

   // One item at a time: no new item straight after an acceptance
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while another is in progress");

   // Reset drops any pending result
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Configuration port always takes a write
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write stalled");

endmodule

bind first_fit_region_allocator ffra_checker u_ffra_checker (.*);

`default_nettype wire

// ===== dv/tb_first_fit_region_allocator.sv =====
// Self-checking testbench of the first-fit region allocator: directed and random tests.
`timescale 1ns / 1ps

module tb_first_fit_region_allocator;
   import ffra_pkg::*;

   // Clock, reset and block ports
   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req       = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_index = 1'b0;
   logic [ADDR_W-1:0] csr_wdata = '0;

   // Shadow copy of the allocator: registers and region list
   logic [TYPE_W-1:0]  usable_type_copy = USABLE_TYPE_RESET;
   logic [ADDR_W-1:0]  min_base_copy    = MIN_BASE_RESET;
   logic [ADDR_W-1:0]  base_list  [MAX_REGIONS];
   logic [PAGES_W-1:0] pages_list [MAX_REGIONS];
   int                 region_total = 0;

   // Outcomes of accepted items still to come out of the block
   rsp_type pending_outcomes [$];

   int   error_count     = 0;
   bit   pacing_on       = 1'b1;
   int   rsp_hold_cycles = 0;

   first_fit_region_allocator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // Bound the run: far beyond the slowest legal sequence of full scans
   initial begin : watchdog
      #(30_000_000);
      $display("tb_first_fit_region_allocator: errors");
      $finish;
   end

   // Full-width random values
   function automatic logic [ADDR_W-1:0] rand52();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[ADDR_W-1:0];
   endfunction

   function automatic logic [PAGES_W-1:0] rand40();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[PAGES_W-1:0];
   endfunction

   // Work out the result of one item and update the shadow region list
   function automatic rsp_type first_fit_outcome(input req_type item);
      rsp_type            outcome;
      logic [PAGES_W-1:0] need;
      logic [ADDR_W-1:0]  advance;
      bit                 found;
      int                 j;
      outcome.status          = STATUS_DONE;
      outcome.granted_address = '0;
      if (item.command == CMD_ADD) begin
         // Capacity is tested before the filter
         if (region_total >= MAX_REGIONS - 1) begin
            outcome.status = STATUS_FULL;
         end else if (item.descriptor_type != usable_type_copy ||
                      item.region_start < min_base_copy) begin
            outcome.status = STATUS_REJECTED;
         end else begin
            base_list[region_total]  = item.region_start;
            pages_list[region_total] = item.region_page_count;
            region_total++;
         end
      end else begin
         // Round the byte count up to whole pages
         need = PAGES_W'(item.request_bytes >> PAGE_SHIFT);
         if (item.request_bytes[PAGE_SHIFT-1:0] != '0) need = need + PAGES_W'(1);
         advance = ADDR_W'(need) << PAGE_SHIFT;
         found   = 1'b0;
         for (j = 0; j < region_total && !found; j++) begin
            if (pages_list[j] >= need) begin
               outcome.granted_address = base_list[j];
               pages_list[j] = pages_list[j] - need;
               base_list[j]  = base_list[j] + advance;
               found = 1'b1;
            end
         end
         if (!found) outcome.status = STATUS_NO_FIT;
      end
      return outcome;
   endfunction

   // Item builders; fields the command ignores carry random values
   function automatic req_type add_item(input logic [TYPE_W-1:0] dtype,
                                        input logic [ADDR_W-1:0] start,
                                        input logic [PAGES_W-1:0] pages);
      req_type item;
      item.command           = CMD_ADD;
      item.descriptor_type   = dtype;
      item.region_start      = start;
      item.region_page_count = pages;
      item.request_bytes     = rand40();
      return item;
   endfunction

   function automatic req_type alloc_item(input logic [BYTES_W-1:0] bytes);
      req_type item;
      item.command           = CMD_ALLOC;
      item.descriptor_type   = TYPE_W'($urandom());
      item.region_start      = rand52();
      item.region_page_count = rand40();
      item.request_bytes     = bytes;
      return item;
   endfunction

   // Mostly well-formed adds and allocates, with noise and rejected descriptors.
   // Stored regions keep below 2^28 pages so that a full-size request can miss them all.
   function automatic req_type random_request();
      req_type item;
      int      kind;
      int      p;
      item = alloc_item(rand40());
      if ($urandom_range(0, 99) < 35) begin
         item.command = CMD_ADD;
         kind = $urandom_range(0, 99);
         if (kind < 75 && region_total < 100) begin
            item.descriptor_type = usable_type_copy;
            if ($urandom_range(0, 3) != 0) item.region_start[PAGE_SHIFT-1:0] = '0;
            item.region_start = item.region_start | min_base_copy;
            p = $urandom_range(0, 99);
            if (p < 55) item.region_page_count = PAGES_W'($urandom_range(0, 16));
            else if (p < 85) item.region_page_count = PAGES_W'($urandom_range(0, 65535));
            else item.region_page_count = rand40() & 40'hFFF_FFFF;
         end else if (kind < 85 && min_base_copy != '0) begin
            // Right type, start below the minimum base
            item.descriptor_type = usable_type_copy;
            item.region_start    = item.region_start % min_base_copy;
         end else if (item.descriptor_type == usable_type_copy) begin
            item.descriptor_type[0] = ~item.descriptor_type[0];
         end
      end else begin
         p = $urandom_range(0, 99);
         if (p < 35) item.request_bytes = BYTES_W'($urandom_range(0, 20000));
         else if (p < 55) item.request_bytes = BYTES_W'($urandom_range(0, 16) * 4096);
         else if (p < 80) item.request_bytes = BYTES_W'($urandom_range(0, 1 << 20));
         else if (p < 90) item.request_bytes = BYTES_W'($urandom_range(0, 1 << 30));
      end
      return item;
   endfunction

   task automatic flag_mismatch(input string what);
      if (error_count < 100) $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Offer one item after a random gap and hold it until accepted
   task automatic send_item(input req_type item);
      int gap;
      gap = pacing_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req       <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      pending_outcomes.push_back(first_fit_outcome(item));
   endtask

   // Drop valid and wait until every outcome has come out
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic index, input logic [ADDR_W-1:0] value);
      settle_block();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      if (index == CSR_USABLE_TYPE) usable_type_copy = value[TYPE_W-1:0];
      else min_base_copy = value;
   endtask

   // Result side: optional long hold-off, then a random stall before each item
   initial begin : result_receiver
      int stall;
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = pacing_on ? $urandom_range(0, 5) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Compare each accepted result with the oldest outcome
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            flag_mismatch("result item with no outcome pending");
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp.status !== want.status)
               flag_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
            if (rsp.granted_address !== want.granted_address)
               flag_mismatch($sformatf("granted_address %h, expected %h",
                                       rsp.granted_address, want.granted_address));
         end
      end
   end

   task automatic test_empty_list();
      send_item(alloc_item('0));
      send_item(alloc_item(40'd4096));
   endtask

   // Default filter: type 7, start from 0x300000
   task automatic test_add_filter();
      send_item(add_item(8'd7, 52'h2F_F000, 40'd5));
      send_item(add_item(8'd6, 52'h30_0000, 40'd5));
      send_item(add_item(8'd7, 52'h30_0000, 40'd2));
      send_item(add_item(8'd7, 52'h40_0000, 40'd0));
   endtask

   // Rounding, zero-byte requests and an exhausted region
   task automatic test_allocate_rounding();
      send_item(alloc_item('0));
      send_item(alloc_item(40'd1));
      send_item(alloc_item(40'd4096));
      send_item(alloc_item(40'd4097));
      send_item(alloc_item('0));
   endtask

   // Region at address zero, and a base that wraps past the top
   task automatic test_zero_base_and_wrap();
      write_register(CSR_MIN_BASE, '0);
      send_item(add_item(8'd7, '0, 40'd3));
      send_item(add_item(8'd7, 52'hF_FFFF_FFFF_F000, 40'h1000_0000));
      send_item(alloc_item(40'd8192));
      send_item(alloc_item('1));
      send_item(alloc_item(40'd4096));
   endtask

   task automatic test_config_extremes();
      write_register(CSR_USABLE_TYPE, 52'hF_FFFF_FFFF_FF00);
      write_register(CSR_MIN_BASE, '1);
      send_item(add_item(8'd0, '1, 40'd1));
      send_item(add_item(8'd0, 52'hF_FFFF_FFFF_FFFE, 40'd1));
      write_register(CSR_USABLE_TYPE, 52'h0_0000_0000_00FF);
      send_item(add_item(8'hFF, '1, 40'd1));
      send_item(add_item(8'hFE, '1, 40'd1));
   endtask

   // Random traffic over several register settings; the last phase runs without idling
   task automatic test_random_traffic();
      int                phase;
      int                n;
      logic [ADDR_W-1:0] r;
      for (phase = 0; phase < 5; phase++) begin
         r = rand52();
         case (phase)
            0: begin
               write_register(CSR_USABLE_TYPE, ADDR_W'(USABLE_TYPE_RESET));
               write_register(CSR_MIN_BASE, MIN_BASE_RESET);
            end
            1: begin
               write_register(CSR_USABLE_TYPE, '0);
               write_register(CSR_MIN_BASE, '0);
            end
            2: begin
               write_register(CSR_USABLE_TYPE, {r[ADDR_W-1:TYPE_W], 8'hFF});
               write_register(CSR_MIN_BASE, rand52());
            end
            3: begin
               write_register(CSR_USABLE_TYPE, r);
               write_register(CSR_MIN_BASE, '1);
            end
            default: begin
               write_register(CSR_USABLE_TYPE, r);
               write_register(CSR_MIN_BASE, rand52() >> 8);
            end
         endcase
         pacing_on = (phase != 4);
         for (n = 0; n < 110; n++) send_item(random_request());
      end
      pacing_on = 1'b1;
   endtask

   // Hold the result side off while items keep coming, so the input stalls
   task automatic test_backpressure();
      int n;
      pacing_on       = 1'b0;
      rsp_hold_cycles = 300;
      for (n = 0; n < 12; n++) send_item(random_request());
      pacing_on = 1'b1;
   endtask

   task automatic finish_run();
      settle_block();
      repeat (4) @(posedge clock);
      if (error_count == 0) $display("tb_first_fit_region_allocator: clean");
      else $display("tb_first_fit_region_allocator: errors");
      $finish;
   endtask

   initial begin : test_sequence
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_add_filter();
      test_allocate_rounding();
      test_zero_base_and_wrap();
      test_config_extremes();
      test_random_traffic();
      test_backpressure();
      finish_run();
   end

endmodule
